/* design/rrtt_pkg.sv */
// shared types and codes for the round-robin task table
package rrtt_pkg;

  // index width for the largest supported table (64 slots)
  localparam int unsigned SLOT_IDX_W = 6;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned SLOT_IN_W  = 3;
  localparam int unsigned RES_W      = 3;
  localparam int unsigned DEF_TASK_SLOTS = 8;

  // operation codes on the input beat
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_CREATE   = 3'd1,
    MODE_REMOVE   = 3'd2,
    MODE_SCHEDULE = 3'd3,
    MODE_SERVICE  = 3'd4,
    MODE_SUSPEND  = 3'd5
  } mode_e;

  // per-slot task status
  typedef enum logic [2:0] {
    ST_CLEAN     = 3'd0,
    ST_NEW       = 3'd1,
    ST_READY     = 3'd2,
    ST_RUNNING   = 3'd3,
    ST_SUSPENDED = 3'd4,
    ST_DIRTY     = 3'd5
  } status_e;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_TICK    = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_SERVICE = 3'd3,
    OP_SUSPEND = 3'd4,
    OP_CREATE  = 3'd5,
    OP_RUN     = 3'd6,
    OP_READY   = 3'd7
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [ENTRY_W-1:0]    entry;
    logic [TICKS_W-1:0]    ticks;
    logic [SLOT_IDX_W-1:0] cur;
  } cell_cmd_t;

  // search wave passed from cell to cell
  typedef struct packed {
    logic                  run;
    logic                  nd;
    logic                  cl_v;
    logic [SLOT_IDX_W-1:0] cl_idx;
    logic                  hi_v;
    logic [SLOT_IDX_W-1:0] hi_idx;
    logic                  lo_v;
    logic [SLOT_IDX_W-1:0] lo_idx;
  } scan_t;

endpackage

/* design/round_robin_task_table_top.sv */
// round-robin task table: controller, output register and the row of slot cells
//
// A table of TASK_SLOTS task slots, slot 0 being the kernel, one cell per slot.
// Tick, remove, service and suspend are broadcast to all cells at once (the unused modes
// as a no-op) and are answered without a search. Create and schedule send a search wave
// down the row of cells, one cell per cycle, then commit the winner. One operation is in
// flight at a time; the result sits in an output register and the next beat is taken as
// soon as that register is empty or being read. Result and current slot numbers carry the
// low 3 bits of the slot index.
module round_robin_task_table_top import rrtt_pkg::*; #(
  parameter int unsigned TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [SLOT_IN_W-1:0] slot_i,
  input  logic [ENTRY_W-1:0]   entry_address_i,
  input  logic [TICKS_W-1:0]   sleep_ticks_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [RES_W-1:0]     result_slot_o,
  output logic                 ok_o,
  output logic [RES_W-1:0]     current_slot_o
);

  localparam int unsigned SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic                  sched_q, sched_d;
  logic [ENTRY_W-1:0]    entry_q, entry_d;
  logic [SlotW-1:0]      cur_q, cur_d;
  logic                  out_valid_q, out_valid_d;
  logic [RES_W-1:0]      res_q, res_d;
  logic                  ok_q, ok_d;
  logic [RES_W-1:0]      cur_out_q, cur_out_d;

  logic                  accept;
  cell_cmd_t             cmd;
  logic [SLOT_IDX_W-1:0] tgt;
  logic [SLOT_IDX_W-1:0] res_idx;
  scan_t                 launch;
  scan_t                 chain [TASK_SLOTS+1];
  scan_t                 done;
  logic [TASK_SLOTS-1:0] sel;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign done       = chain[TASK_SLOTS];

  // controller: decode beats, launch searches, commit winners
  always_comb begin
    state_d     = state_q;
    sched_d     = sched_q;
    entry_d     = entry_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    ok_d        = ok_q;
    cur_out_d   = cur_out_q;
    cmd.op      = OP_NOP;
    cmd.entry   = entry_q;
    cmd.ticks   = sleep_ticks_i;
    cmd.cur     = SLOT_IDX_W'(cur_q);
    tgt         = SLOT_IDX_W'(slot_i);
    res_idx     = '0;
    launch      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          entry_d     = entry_address_i;
          out_valid_d = 1'b1;
          res_d       = '0;
          ok_d        = 1'b1;
          cur_out_d   = RES_W'(SLOT_IDX_W'(cur_q));
          unique case (mode_i)
            MODE_TICK:    cmd.op = OP_TICK;
            MODE_REMOVE:  cmd.op = OP_REMOVE;
            MODE_SERVICE: cmd.op = OP_SERVICE;
            MODE_SUSPEND: cmd.op = OP_SUSPEND;
            MODE_CREATE, MODE_SCHEDULE: begin
              out_valid_d = 1'b0;
              launch.run  = 1'b1;
              sched_d     = (mode_i == MODE_SCHEDULE);
              state_d     = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (done.run) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          ok_d        = 1'b1;
          if (!sched_q) begin
            // create: first clean slot, if any
            if (done.cl_v) begin
              cmd.op  = OP_CREATE;
              tgt     = done.cl_idx;
              res_idx = done.cl_idx;
            end else begin
              ok_d = 1'b0;
            end
          end else begin
            // schedule: kernel while work is pending, else round-robin, else kernel if nothing is ready
            priority if (done.nd) begin
              cmd.op = OP_READY;
              tgt    = '0;
              cur_d  = '0;
            end else if (done.hi_v) begin
              cmd.op  = OP_RUN;
              tgt     = done.hi_idx;
              res_idx = done.hi_idx;
              cur_d   = done.hi_idx[SlotW-1:0];
            end else if (done.lo_v) begin
              cmd.op  = OP_RUN;
              tgt     = done.lo_idx;
              res_idx = done.lo_idx;
              cur_d   = done.lo_idx[SlotW-1:0];
            end else begin
              cmd.op = OP_READY;
              tgt    = '0;
              cur_d  = '0;
            end
          end
          res_d     = res_idx[RES_W-1:0];
          cur_out_d = RES_W'(SLOT_IDX_W'(cur_d));
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sched_q     <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sched_q     <= sched_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    entry_q   <= entry_d;
    res_q     <= res_d;
    ok_q      <= ok_d;
    cur_out_q <= cur_out_d;
  end

  assign chain[0] = launch;

  // row of slot cells
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    assign sel[i] = (tgt == SLOT_IDX_W'(i));
    rrtt_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .sel_i (sel[i]),
      .scan_i(chain[i]),
      .scan_o(chain[i+1])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign result_slot_o  = res_q;
  assign ok_o           = ok_q;
  assign current_slot_o = cur_out_q;

endmodule

/* design/rrtt_cell.sv */
// one task slot: status, sleep countdown, entry address and a search stage
module rrtt_cell import rrtt_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      sel_i,
  input  scan_t     scan_i,
  output scan_t     scan_o
);

  localparam logic [SLOT_IDX_W-1:0] MyIdx = SLOT_IDX_W'(CellIdx);
  localparam status_e RstStatus = (CellIdx == 0) ? ST_RUNNING : ST_CLEAN;
  localparam bit IsKernel = (CellIdx == 0);

  status_e            status_q, status_d;
  logic [TICKS_W-1:0] count_q, count_d;
  logic [ENTRY_W-1:0] entry_q, entry_d;
  scan_t              scan_q, scan_d;

  // slot state update from the broadcast command
  always_comb begin
    status_d = status_q;
    count_d  = count_q;
    entry_d  = entry_q;
    unique case (cmd_i.op)
      OP_TICK: begin
        if (status_q == ST_SUSPENDED && count_q != '0) begin
          count_d = count_q - TICKS_W'(1);
          if (count_q == TICKS_W'(1)) status_d = ST_READY;
        end
      end
      OP_REMOVE: begin
        if (sel_i) status_d = ST_DIRTY;
      end
      OP_SERVICE: begin
        if (!IsKernel) begin
          if (status_q == ST_DIRTY) begin
            status_d = ST_CLEAN;
            count_d  = '0;
          end else if (status_q == ST_NEW) begin
            status_d = ST_READY;
          end
        end
      end
      OP_SUSPEND: begin
        if (sel_i) begin
          status_d = ST_SUSPENDED;
          count_d  = cmd_i.ticks;
        end
      end
      OP_CREATE: begin
        if (sel_i) begin
          status_d = ST_NEW;
          entry_d  = cmd_i.entry;
        end
      end
      OP_RUN: begin
        if (sel_i) status_d = ST_RUNNING;
      end
      OP_READY: begin
        if (sel_i) status_d = ST_READY;
      end
      default: begin
      end
    endcase
  end

  // search stage: fold this slot into the wave coming from the left
  always_comb begin
    scan_d = scan_i;
    if (scan_i.run) begin
      if (!IsKernel && (status_q == ST_NEW || status_q == ST_DIRTY)) scan_d.nd = 1'b1;
      if (!scan_i.cl_v && status_q == ST_CLEAN) begin
        scan_d.cl_v   = 1'b1;
        scan_d.cl_idx = MyIdx;
      end
      if (!scan_i.hi_v && status_q == ST_READY && MyIdx > cmd_i.cur) begin
        scan_d.hi_v   = 1'b1;
        scan_d.hi_idx = MyIdx;
      end
      if (!IsKernel && !scan_i.lo_v && status_q == ST_READY && MyIdx <= cmd_i.cur) begin
        scan_d.lo_v   = 1'b1;
        scan_d.lo_idx = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= RstStatus;
      count_q  <= '0;
      entry_q  <= '0;
      scan_q   <= '0;
    end else begin
      status_q <= status_d;
      count_q  <= count_d;
      entry_q  <= entry_d;
      scan_q   <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule
